@@ sv/ptci_pkg.sv @@
package ptci_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_INDEX_W = 1;

  // restoring divide steps: one overflow bit plus eight quotient bits
  localparam int DIV_STEPS = 9;
  // stages inside a lane: multiply, div-by-255, memory read, products,
  // numerator, then the divide steps
  localparam int LANE_LATENCY = 5 + DIV_STEPS;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_MAP   = 1'b1;

  localparam logic [1:0] CURVE_INTENSITY = 2'd0;
  localparam logic [1:0] CURVE_RED       = 2'd1;
  localparam logic [1:0] CURVE_GREEN     = 2'd2;
  localparam logic [1:0] CURVE_BLUE      = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_POINT_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE  = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [1:0]       curve_select;
    logic [PIX_W-1:0] point_index;
    logic [PIX_W-1:0] point_value;
    logic [PIX_W-1:0] blue_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] red_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] red_out;
  } out_item_t;

  // per-lane command, loaded at the input stage
  typedef struct packed {
    logic             write;  // curve point write aimed at this lane
    logic             curve;  // 0 intensity half, 1 colour half of lane memory
    logic [PIX_W-1:0] point_index;
    logic [PIX_W-1:0] point_value;
    logic [PIX_W-1:0] x;      // pixel byte
  } lane_cmd_t;

  typedef struct packed {
    logic en;          // pipeline advance
    logic color_mode;  // read half of lane memory
  } lane_ctl_t;

endpackage

@@ sv/ptci_stream_if.sv @@
interface ptci_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/ptci_ram.sv @@
module ptci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/ptci_lane.sv @@
module ptci_lane #(
  parameter int MAX_POINTS = 256,
  localparam int DW = $clog2(MAX_POINTS)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ptci_pkg::lane_ctl_t      ctl,
  input  ptci_pkg::lane_cmd_t      cmd,
  input  logic [DW-1:0]            last_point,
  output logic [ptci_pkg::PIX_W-1:0] level
);

  localparam int PW    = ptci_pkg::PIX_W + DW;
  localparam int HALF  = (MAX_POINTS + 1) / 2;
  localparam int HW    = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int AW    = HW + 1;
  localparam int NW    = ((DW > 17) ? DW : 17) + 1;
  localparam int EW    = (NW > DW + 9) ? NW : DW + 9;
  localparam int STEPS = ptci_pkg::DIV_STEPS;

  // stage 1: pos = x * D
  logic          s1_write;
  logic          s1_curve;
  logic [7:0]    s1_idx;
  logic [7:0]    s1_val;
  logic [PW-1:0] s1_pos;

  // stage 2: coarse quotient of pos / 255
  logic          s2_write;
  logic          s2_curve;
  logic [7:0]    s2_idx;
  logic [7:0]    s2_val;
  logic [PW-1:0] s2_pos;
  logic [DW-1:0] s2_q0;

  logic [PW+8:0] mul257;
  logic [PW:0]   rem_wide;
  logic [8:0]    r0;
  logic          r_ge;
  logic [DW-1:0] seg;
  logic [7:0]    frac;
  logic [HW-1:0] seg_half;
  logic [HW-1:0] wr_half;
  logic [AW-1:0] even_raddr;
  logic [AW-1:0] odd_raddr;
  logic [AW-1:0] waddr;
  logic [7:0]    even_q;
  logic [7:0]    odd_q;

  // stage 3: aligned with memory read data
  logic       s3_odd;
  logic [7:0] s3_frac;
  logic [7:0] c_lo;
  logic [7:0] c_hi;

  // stage 4: products
  logic [15:0] p_lo;
  logic [15:0] p_hi;
  logic [16:0] p_sum;

  // divider pipeline
  logic [EW-1:0]    den;
  logic [NW-1:0]    rem [0:STEPS];
  logic [STEPS-1:0] quo [0:STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_write <= 1'b0;
      s2_write <= 1'b0;
    end else if (ctl.en) begin
      s1_write <= cmd.write;
      s2_write <= s1_write;
    end
  end

  assign mul257 = (PW + 9)'(s1_pos) + ((PW + 9)'(s1_pos) << 8);

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      s1_curve <= cmd.curve;
      s1_idx   <= cmd.point_index;
      s1_val   <= cmd.point_value;
      s1_pos   <= PW'(cmd.x) * PW'(last_point);
      s2_curve <= s1_curve;
      s2_idx   <= s1_idx;
      s2_val   <= s1_val;
      s2_pos   <= s1_pos;
      s2_q0    <= mul257[16 +: DW];
    end
  end

  // exact remainder: the coarse quotient is short by at most one
  always_comb begin
    rem_wide   = (PW + 1)'(s2_pos) - ((PW + 1)'(s2_q0) << 8) + (PW + 1)'(s2_q0);
    r0         = rem_wide[8:0];
    r_ge       = (r0 >= 9'd255);
    seg        = s2_q0 + DW'(r_ge);
    frac       = r_ge ? 8'(r0 - 9'd255) : r0[7:0];
    seg_half   = HW'(seg >> 1);
    wr_half    = HW'(s2_idx >> 1);
    // even bank holds points 2m, odd bank points 2m+1
    even_raddr = {ctl.color_mode, HW'(seg_half + HW'(seg[0]))};
    odd_raddr  = {ctl.color_mode, seg_half};
    waddr      = {s2_curve, wr_half};
  end

  ptci_ram #(
    .WIDTH (8),
    .DEPTH (2 ** AW)
  ) u_bank_even (
    .clk   (clk),
    .we    (ctl.en & s2_write & ~s2_idx[0]),
    .waddr (waddr),
    .wdata (s2_val),
    .re    (ctl.en),
    .raddr (even_raddr),
    .rdata (even_q)
  );

  ptci_ram #(
    .WIDTH (8),
    .DEPTH (2 ** AW)
  ) u_bank_odd (
    .clk   (clk),
    .we    (ctl.en & s2_write & s2_idx[0]),
    .waddr (waddr),
    .wdata (s2_val),
    .re    (ctl.en),
    .raddr (odd_raddr),
    .rdata (odd_q)
  );

  assign c_lo  = s3_odd ? odd_q : even_q;
  assign c_hi  = s3_odd ? even_q : odd_q;
  assign p_sum = 17'(p_lo) + 17'(p_hi);
  assign den   = EW'({last_point, 1'b0});
  assign quo[0] = '0;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      s3_odd  <= seg[0];
      s3_frac <= frac;
      p_lo    <= 16'(c_lo) * 16'(8'(8'd255 - s3_frac));
      // upper point has zero weight on a segment start (may lie past the table)
      p_hi    <= (s3_frac == 8'd0) ? 16'd0 : 16'(c_hi) * 16'(s3_frac);
      rem[0]  <= (NW'(p_sum) << 1) + NW'(last_point);
    end
  end

  // one quotient bit per stage, MSB first; MSB set means saturate
  for (genvar k = 1; k <= STEPS; k++) begin : g_div
    localparam int SH = STEPS - k;
    logic [EW-1:0] trial;
    logic          take;

    assign trial = EW'(rem[k-1]);
    assign take  = (trial >= (den << SH));

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem[k] <= take ? NW'(trial - (den << SH)) : rem[k-1];
        quo[k] <= {quo[k-1][STEPS-2:0], take};
      end
    end
  end

  assign level = quo[STEPS][STEPS-1] ? 8'hFF : quo[STEPS][7:0];

endmodule

@@ sv/pixel_tone_curve_interpolate_unit.sv @@
// An accepted pixel item passes through the lane stages and the output register to item_out.
// Throughput: one item per clock while item_out is not stalled; curve writes and pixels may interleave freely.
// The whole pipeline advances together; ready drops only while item_out holds
// a result that has not been taken.
// Reset (rst, synchronous): pipeline and output valid cleared, point count 256
// (or MAX_POINTS if smaller), gray mode. Curve memories keep their contents.
module pixel_tone_curve_interpolate_unit #(
  parameter int MAX_POINTS = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [ptci_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [ptci_pkg::CFG_DATA_W-1:0]       cfg_data,
  ptci_stream_if.sink                           item_in,
  ptci_stream_if.source                         item_out
);

  localparam int DW      = $clog2(MAX_POINTS);
  localparam int CW      = ((DW + 1 > ptci_pkg::CFG_DATA_W) ? DW + 1 : ptci_pkg::CFG_DATA_W) + 1;
  localparam int D_RESET = ((MAX_POINTS < 256) ? MAX_POINTS : 256) - 1;
  localparam int LAT     = ptci_pkg::LANE_LATENCY;
  localparam int LANES   = 3;

  // Configuration. Only D = N-1 is kept; the raw count is never read back.
  logic [DW-1:0] last_point;
  logic [DW-1:0] last_point_next;
  logic          color_mode;
  logic [CW-1:0] count_in;
  logic [CW-1:0] count_eff;

  always_comb begin
    count_in = CW'(cfg_data);
    if (count_in < CW'(2)) begin
      count_eff = CW'(2);
    end else if (count_in > CW'(MAX_POINTS)) begin
      count_eff = CW'(MAX_POINTS);
    end else begin
      count_eff = count_in;
    end
    last_point_next = DW'(count_eff - CW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_point <= DW'(D_RESET);
      color_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptci_pkg::REG_POINT_COUNT: begin
          last_point <= last_point_next;
        end
        ptci_pkg::REG_COLOR_MODE: begin
          color_mode <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake: one stall signal for every stage, output register included.
  logic en;
  logic accept;
  logic map_accept;
  logic write_ok;

  assign en         = ~item_out.valid | item_out.ready;
  assign item_in.ready = en;
  assign accept     = item_in.valid & en;
  assign map_accept = accept & (item_in.data.opcode == ptci_pkg::OP_MAP);
  // writes past the table are dropped
  assign write_ok   = accept & (item_in.data.opcode == ptci_pkg::OP_WRITE)
                    & (32'(item_in.data.point_index) < MAX_POINTS);

  // Lane 0 maps blue, lane 1 green, lane 2 red. Each lane memory holds the intensity curve
  // in one half and the lane's own colour curve in the other, so an
  // intensity write goes to all three lanes.
  localparam logic [1:0] LANE_CURVE [LANES] = '{
    ptci_pkg::CURVE_BLUE, ptci_pkg::CURVE_GREEN, ptci_pkg::CURVE_RED
  };

  ptci_pkg::lane_ctl_t ctl;
  ptci_pkg::lane_cmd_t cmd   [LANES];
  logic [7:0]          xs    [LANES];
  logic [7:0]          level [LANES];

  assign ctl.en         = en;
  assign ctl.color_mode = color_mode;
  assign xs[0] = item_in.data.blue_in;
  assign xs[1] = item_in.data.green_in;
  assign xs[2] = item_in.data.red_in;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      cmd[l].write = write_ok
                   & ((item_in.data.curve_select == ptci_pkg::CURVE_INTENSITY)
                   || (item_in.data.curve_select == LANE_CURVE[l]));
      cmd[l].curve = (item_in.data.curve_select != ptci_pkg::CURVE_INTENSITY);
      cmd[l].point_index = item_in.data.point_index;
      cmd[l].point_value = item_in.data.point_value;
      cmd[l].x           = xs[l];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    ptci_lane #(
      .MAX_POINTS (MAX_POINTS)
    ) u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .cmd        (cmd[l]),
      .last_point (last_point),
      .level      (level[l])
    );
  end

  // Valid bits track pixel items through the lanes; writes leave no result.
  logic [LAT-1:0] vpipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe          <= '0;
      item_out.valid <= 1'b0;
    end else if (en) begin
      vpipe          <= {vpipe[LAT-2:0], map_accept};
      item_out.valid <= vpipe[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_out.data.blue_out  <= level[0];
      item_out.data.green_out <= level[1];
      item_out.data.red_out   <= level[2];
    end
  end

endmodule

@@ sv/ptci_checker.sv @@
module ptci_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ptci_pkg::out_item_t out_data
);

  // a result not taken stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // input is refused only while a result waits on the output
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("ready does not follow output backpressure");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled input item is never taken without ready
  a_no_accept_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

bind pixel_tone_curve_interpolate_unit ptci_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item_in.valid),
  .in_ready  (item_in.ready),
  .out_valid (item_out.valid),
  .out_ready (item_out.ready),
  .out_data  (item_out.data)
);
